/* sv/hsfr_pkg.sv */
// ----------------------------------------------------------------------------
// hsfr_pkg: frame receiver shared definitions
// Octet codes, field widths, result kinds and receive phases.
// ----------------------------------------------------------------------------
package hsfr_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 13;
	localparam int KIND_W = 2;

	localparam int unsigned MAX_CAPACITY = 4096;

	localparam logic [LEN_W-1:0] CAP_RESET = LEN_W'(2048);
	localparam logic [LEN_W-1:0] CAP_LIMIT = LEN_W'(MAX_CAPACITY);

	localparam logic [BYTE_W-1:0] FLAG_OCTET = 8'h7E;
	localparam logic [BYTE_W-1:0] ESC_OCTET  = 8'h7D;
	localparam logic [BYTE_W-1:0] ESC_FLIP   = 8'h20;

	localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DONE    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ABORT   = 2'd2;

	typedef enum logic [4:0] {
		PH_WAIT = 5'b00001,
		PH_ADDR = 5'b00010,
		PH_CTRL = 5'b00100,
		PH_DATA = 5'b01000,
		PH_ESC  = 5'b10000
	} phase_t;

endpackage

/* sv/hdlc_style_frame_receiver.sv */
// ----------------------------------------------------------------------------
// hdlc_style_frame_receiver: byte-wise HDLC-style deframer
// Line octets enter on the line channel (line_valid / line_stall). After a
// 0x7E start flag the next two octets are held as address and control;
// further octets are payload, 0x7D escapes the next octet (bit 5 flipped).
// Each payload octet gives a result; a closing flag gives frame complete.
// Once the stored count reaches payload_capacity (saturated at 4096) the
// next octet is dropped, an abort result is given and the receiver waits
// for a new start flag. Address, control, start flag and escape octets
// give no result. Results leave on the result channel (result_valid /
// result_stall). payload_capacity is written on the cfg channel, which is
// always ready. One octet per cycle is sustained while the result side is
// not stalled: a line register feeds one pass of phase logic into a result
// register, and both advance whenever the result register is empty or
// being taken. A stall on the result side backs up into line_stall after
// the line register fills. Reset clears the phase, the held octets and the
// count, and sets the capacity to 2048.
// ----------------------------------------------------------------------------
module hdlc_style_frame_receiver (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [hsfr_pkg::LEN_W-1:0]   payload_capacity,
	input  logic                         line_valid,
	output logic                         line_stall,
	input  logic [hsfr_pkg::BYTE_W-1:0]  line_byte,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [hsfr_pkg::KIND_W-1:0]  result_kind,
	output logic [hsfr_pkg::BYTE_W-1:0]  frame_address,
	output logic [hsfr_pkg::BYTE_W-1:0]  frame_control,
	output logic [hsfr_pkg::BYTE_W-1:0]  payload_byte,
	output logic [hsfr_pkg::LEN_W-1:0]   payload_length
);
	import hsfr_pkg::*;

	logic [LEN_W-1:0]  capacity_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	phase_t            phase_q;
	logic [BYTE_W-1:0] address_q;
	logic [BYTE_W-1:0] control_q;
	logic [LEN_W-1:0]  count_q;

	logic              valid_s2;
	logic [KIND_W-1:0] kind_s2;
	logic [BYTE_W-1:0] address_s2;
	logic [BYTE_W-1:0] control_s2;
	logic [BYTE_W-1:0] byte_s2;
	logic [LEN_W-1:0]  length_s2;

	logic              out_free;
	logic              advance;
	logic [LEN_W-1:0]  cap_eff;
	logic [LEN_W-1:0]  count_inc;
	logic              emit;
	logic [KIND_W-1:0] kind_n;
	logic [BYTE_W-1:0] byte_n;
	logic [LEN_W-1:0]  length_n;
	phase_t            phase_n;
	logic [BYTE_W-1:0] address_n;
	logic [BYTE_W-1:0] control_n;
	logic [LEN_W-1:0]  count_n;

	assign cfg_ready  = 1'b1;
	assign out_free   = !valid_s2 || !result_stall;
	assign advance    = valid_s1 && out_free;
	assign line_stall = valid_s1 && !out_free;

	assign cap_eff   = (capacity_q > CAP_LIMIT) ? CAP_LIMIT : capacity_q;
	assign count_inc = count_q + LEN_W'(1);

	always_comb begin
		emit      = 1'b0;
		kind_n    = KIND_PAYLOAD;
		byte_n    = '0;
		length_n  = count_q;
		phase_n   = phase_q;
		address_n = address_q;
		control_n = control_q;
		count_n   = count_q;
		if (count_q >= cap_eff) begin
			emit    = 1'b1;
			kind_n  = KIND_ABORT;
			count_n = '0;
			phase_n = PH_WAIT;
		end else begin
			case (phase_q)
				PH_ADDR: begin
					address_n = byte_s1;
					phase_n   = PH_CTRL;
				end
				PH_CTRL: begin
					control_n = byte_s1;
					phase_n   = PH_DATA;
				end
				PH_DATA: begin
					if (byte_s1 == ESC_OCTET) begin
						phase_n = PH_ESC;
					end else if (byte_s1 == FLAG_OCTET) begin
						emit    = 1'b1;
						kind_n  = KIND_DONE;
						count_n = '0;
						phase_n = PH_WAIT;
					end else begin
						emit     = 1'b1;
						byte_n   = byte_s1;
						count_n  = count_inc;
						length_n = count_inc;
					end
				end
				PH_ESC: begin
					emit     = 1'b1;
					byte_n   = byte_s1 ^ ESC_FLIP;
					count_n  = count_inc;
					length_n = count_inc;
					phase_n  = PH_DATA;
				end
				default: begin
					phase_n = (byte_s1 == FLAG_OCTET) ? PH_ADDR : PH_WAIT;
				end
			endcase
		end
	end

	// line register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!line_stall) begin
			valid_s1 <= line_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!line_stall && line_valid) begin
			byte_s1 <= line_byte;
		end
	end

	// receive state and capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
			phase_q    <= PH_WAIT;
			address_q  <= '0;
			control_q  <= '0;
			count_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				capacity_q <= payload_capacity;
			end
			if (advance) begin
				phase_q   <= phase_n;
				address_q <= address_n;
				control_q <= control_n;
				count_q   <= count_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			kind_s2    <= kind_n;
			address_s2 <= address_n;
			control_s2 <= control_n;
			byte_s2    <= byte_n;
			length_s2  <= length_n;
		end
	end

	assign result_valid   = valid_s2;
	assign result_kind    = kind_s2;
	assign frame_address  = address_s2;
	assign frame_control  = control_s2;
	assign payload_byte   = byte_s2;
	assign payload_length = length_s2;

endmodule

/* sim/hdlc_style_frame_receiver_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hdlc_style_frame_receiver_tb: self-checking bench for the frame receiver
// Feeds line octets in random bursts while the result side stalls on its own
// pattern. A tracker class follows the deframing state for each accepted
// octet, queues the results it must cause and checks each result the block
// hands out, field by field. Covers flags and escapes in every position,
// capacity zero, one, small values, the maximum and saturated values.
// ----------------------------------------------------------------------------
module hdlc_style_frame_receiver_tb;
	import hsfr_pkg::*;

	localparam int CYCLE_LIMIT = 500000;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] addr;
		logic [BYTE_W-1:0] ctrl;
		logic [BYTE_W-1:0] octet;
		logic [LEN_W-1:0]  len;
	} frame_result_t;

	class deframe_tracker;
		logic [LEN_W-1:0]  capacity;
		phase_t            phase;
		logic [BYTE_W-1:0] held_addr;
		logic [BYTE_W-1:0] held_ctrl;
		logic [LEN_W-1:0]  stored;
		frame_result_t     due_results[$];
		int                failures;

		function new();
			capacity  = CAP_RESET;
			phase     = PH_WAIT;
			held_addr = '0;
			held_ctrl = '0;
			stored    = '0;
			failures  = 0;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void flag_problem(string msg);
			failures++;
			if (failures <= 10)
				$display("%0t: %s", $time, msg);
		endfunction

		function void queue_result(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] octet,
				logic [LEN_W-1:0] len);
			frame_result_t r;
			r.kind  = kind;
			r.addr  = held_addr;
			r.ctrl  = held_ctrl;
			r.octet = octet;
			r.len   = len;
			due_results.push_back(r);
		endfunction

		function void note_octet(logic [BYTE_W-1:0] b);
			logic [LEN_W-1:0] cap;
			cap = (capacity > CAP_LIMIT) ? CAP_LIMIT : capacity;
			// overflow wins over every phase
			if (stored >= cap) begin
				queue_result(KIND_ABORT, '0, stored);
				stored = '0;
				phase  = PH_WAIT;
				return;
			end
			case (phase)
				PH_ADDR: begin
					held_addr = b;
					phase     = PH_CTRL;
				end
				PH_CTRL: begin
					held_ctrl = b;
					phase     = PH_DATA;
				end
				PH_DATA: begin
					if (b == ESC_OCTET) begin
						phase = PH_ESC;
					end else if (b == FLAG_OCTET) begin
						queue_result(KIND_DONE, '0, stored);
						stored = '0;
						phase  = PH_WAIT;
					end else begin
						stored = stored + 1'b1;
						queue_result(KIND_PAYLOAD, b, stored);
					end
				end
				PH_ESC: begin
					stored = stored + 1'b1;
					phase  = PH_DATA;
					queue_result(KIND_PAYLOAD, b ^ ESC_FLIP, stored);
				end
				default: begin
					phase = (b == FLAG_OCTET) ? PH_ADDR : PH_WAIT;
				end
			endcase
		endfunction

		function void check_result(frame_result_t got);
			frame_result_t exp;
			if (due_results.size() == 0) begin
				flag_problem($sformatf("unexpected result: kind %0d addr %02h ctrl %02h octet %02h len %0d",
					got.kind, got.addr, got.ctrl, got.octet, got.len));
				return;
			end
			exp = due_results.pop_front();
			if (got.kind !== exp.kind || got.addr !== exp.addr || got.ctrl !== exp.ctrl ||
					got.octet !== exp.octet || got.len !== exp.len)
				flag_problem($sformatf({"result mismatch: expected kind %0d addr %02h ctrl %02h",
					" octet %02h len %0d, got kind %0d addr %02h ctrl %02h octet %02h len %0d"},
					exp.kind, exp.addr, exp.ctrl, exp.octet, exp.len,
					got.kind, got.addr, got.ctrl, got.octet, got.len));
		endfunction

		function void report_leftover();
			if (due_results.size() != 0)
				flag_problem($sformatf("%0d results never arrived", due_results.size()));
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [LEN_W-1:0]   payload_capacity = CAP_RESET;
	logic               line_valid = 1'b0;
	logic               line_stall;
	logic [BYTE_W-1:0]  line_byte = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [KIND_W-1:0]  result_kind;
	logic [BYTE_W-1:0]  frame_address;
	logic [BYTE_W-1:0]  frame_control;
	logic [BYTE_W-1:0]  payload_byte;
	logic [LEN_W-1:0]   payload_length;

	deframe_tracker tracker = new();

	int cycle_count = 0;
	int burst_left = 0;
	int frame_octets = 0;
	bit no_gaps = 1'b0;
	int stall_mode = 0;
	logic [8:0] mode_left = '0;

	hdlc_style_frame_receiver uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.payload_capacity(payload_capacity),
		.line_valid     (line_valid),
		.line_stall     (line_stall),
		.line_byte      (line_byte),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result_kind    (result_kind),
		.frame_address  (frame_address),
		.frame_control  (frame_control),
		.payload_byte   (payload_byte),
		.payload_length (payload_length)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// result side stall pattern, switching modes now and then
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			mode_left  <= 9'($urandom_range(32, 400));
		end else begin
			mode_left <= mode_left - 1'b1;
		end
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 2) == 0);
			2: result_stall <= (mode_left[3:0] < 4'd11);
			default: result_stall <= mode_left[0];
		endcase
	end

	always @(posedge clk) begin : watch
		frame_result_t seen;
		if (arst_n) begin
			if (line_valid && !line_stall)
				tracker.note_octet(line_byte);
			if (result_valid && !result_stall) begin
				seen.kind  = result_kind;
				seen.addr  = frame_address;
				seen.ctrl  = frame_control;
				seen.octet = payload_byte;
				seen.len   = payload_length;
				tracker.check_result(seen);
			end
		end
	end

	task automatic push_octet(input logic [BYTE_W-1:0] b);
		line_valid <= 1'b1;
		line_byte  <= b;
		do @(posedge clk); while (line_stall);
	endtask

	task automatic idle_line(input int n);
		line_valid <= 1'b0;
		line_byte  <= 8'($urandom);
		repeat (n) @(posedge clk);
	endtask

	task automatic feed(input logic [BYTE_W-1:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0)
				idle_line(gap);
		end
		burst_left--;
		push_octet(b);
	endtask

	// wait until every request has produced its results and the pipe is empty
	task automatic settle();
		line_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_capacity(input logic [LEN_W-1:0] v);
		cfg_valid        <= 1'b1;
		payload_capacity <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tracker.capacity = v;
	endtask

	function automatic logic [BYTE_W-1:0] pick_octet();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return FLAG_OCTET;
		if (r == 1)
			return ESC_OCTET;
		return 8'($urandom);
	endfunction

	task automatic feed_payload_unit();
		logic [BYTE_W-1:0] b;
		b = 8'($urandom);
		if ($urandom_range(0, 9) == 0) begin
			feed(ESC_OCTET);
			feed(pick_octet());
		end else if (b == FLAG_OCTET || b == ESC_OCTET) begin
			feed(ESC_OCTET);
			feed(b ^ ESC_FLIP);
		end else begin
			feed(b);
		end
	endtask

	task automatic send_frame(input int plen, input bit closed);
		int i;
		feed(FLAG_OCTET);
		feed(pick_octet());
		feed(pick_octet());
		for (i = 0; i < plen; i++)
			feed_payload_unit();
		if (closed)
			feed(FLAG_OCTET);
		frame_octets += plen + 3 + int'(closed);
	endtask

	task automatic run_phase(input logic [LEN_W-1:0] cap, input int target, input bit gapless);
		int start;
		int lim;
		int span;
		int plen;
		int pick;
		int n;
		settle();
		write_capacity(cap);
		no_gaps = gapless;
		start = frame_octets;
		lim  = (cap > CAP_LIMIT) ? int'(MAX_CAPACITY) : int'(cap);
		span = (lim < 40) ? lim + 2 : 40;
		while (frame_octets - start < target) begin
			pick = $urandom_range(0, 19);
			if (lim < 40 && $urandom_range(0, 1) == 0)
				plen = $urandom_range((lim > 2) ? lim - 2 : 0, span);
			else
				plen = $urandom_range(0, (span < 8) ? span : 8);
			if (pick < 2) begin
				n = $urandom_range(1, 4);
				repeat (n) feed(pick_octet());
			end else if (pick < 4) begin
				send_frame(plen, 1'b0);
			end else begin
				send_frame(plen, 1'b1);
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// line noise, then a frame with flag and escape octets in every slot
		feed(8'h00); feed(8'hff);
		feed(FLAG_OCTET); feed(FLAG_OCTET); feed(ESC_OCTET);
		feed(8'h00); feed(8'hff);
		feed(ESC_OCTET); feed(FLAG_OCTET);
		feed(ESC_OCTET); feed(ESC_OCTET);
		feed(FLAG_OCTET);
		// empty frame
		feed(FLAG_OCTET); feed(8'ha5); feed(8'h5a); feed(FLAG_OCTET);
		settle();
		write_capacity(13'd1);
		feed(FLAG_OCTET); feed(8'h01); feed(8'h02); feed(8'haa); feed(8'hbb);
		settle();
		write_capacity(13'd0);
		feed(FLAG_OCTET); feed(8'h33);

		run_phase(13'd3, 180, 1'b0);
		run_phase(13'd1, 100, 1'b0);
		run_phase(13'd0, 40, 1'b0);
		run_phase(13'd16, 180, 1'b0);
		run_phase(13'd4096, 120, 1'b0);

		// saturated capacity
		run_phase(13'h1fff, 60, 1'b0);

		run_phase(13'($urandom_range(2, 9)), 160, 1'b0);
		run_phase(13'($urandom_range(1, 4096)), 80, 1'b0);
		run_phase(13'd5, 160, 1'b1);
		run_phase(CAP_RESET, 60, 1'b0);

		settle();
		tracker.report_leftover();
		if (tracker.failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
